FILE: design/mha_pkg.sv
// Package for the magnetometer heading angles block: widths, CORDIC constants and shared types.
`default_nettype none

package mha_pkg;

    localparam int MHA_IN_W        = 16;
    localparam int MHA_OUT_W       = 8;
    localparam int MHA_MAG_W       = MHA_IN_W + 1;
    localparam int MHA_PRESCALE    = 14;
    localparam int MHA_CORDIC_W    = 34;
    localparam int MHA_ANGLE_W     = 32;
    localparam int MHA_STEPS       = 14;
    localparam int MHA_ATAN_COUNT  = 24;
    localparam int MHA_LANES       = 2;

    localparam logic [MHA_ANGLE_W-1:0] MHA_EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [MHA_ANGLE_W-1:0] MHA_QUARTER_TURN = 32'h4000_0000;
    localparam logic [MHA_ANGLE_W-1:0] MHA_HALF_TURN    = 32'h8000_0000;

    // Arctangent of 2^-i in units of 2^-32 turn, truncated.
    localparam logic [MHA_ANGLE_W-1:0] MHA_ATAN_TURNS [MHA_ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic zero_small;
        logic equal;
        logic swapped;
        logic across_neg;
        logic up_neg;
    } t_flags;

endpackage

`default_nettype wire

FILE: design/magnetometer_heading_angles.sv
// Pipelined CORDIC that turns one magnetometer sample into two 8-bit heading angles.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   -------------------------------------------
//  command   start, busy (always low)  i_x_reading, i_z_reading, i_y_reading
//  result    o_done strobe, one cycle  o_heading_xy, o_heading_yz
//
// A new sample may be started in every cycle; busy never rises.
// The result passes through one folding stage, one stage per CORDIC iteration,
// and two stages that unfold the angle.
// The receiver cannot stall, so the pipeline always advances.
// The synchronous reset clears the valid bits; transactions in flight are dropped.
`default_nettype none

module magnetometer_heading_angles #(
    parameter int CORDIC_STEPS = mha_pkg::MHA_STEPS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [mha_pkg::MHA_IN_W-1:0] i_x_reading,
    input  wire logic signed [mha_pkg::MHA_IN_W-1:0] i_z_reading,
    input  wire logic signed [mha_pkg::MHA_IN_W-1:0] i_y_reading,
    output logic                                     o_done,
    output logic             [mha_pkg::MHA_OUT_W-1:0] o_heading_xy,
    output logic             [mha_pkg::MHA_OUT_W-1:0] o_heading_yz
);

    import mha_pkg::*;

    localparam int LAT = CORDIC_STEPS + 3;

    logic [CORDIC_STEPS+2:0] r_vld;

    logic signed [MHA_CORDIC_W-1:0] r_cx  [0:CORDIC_STEPS][0:MHA_LANES-1];
    logic signed [MHA_CORDIC_W-1:0] r_cy  [0:CORDIC_STEPS][0:MHA_LANES-1];
    logic        [MHA_ANGLE_W-1:0]  r_z   [0:CORDIC_STEPS][0:MHA_LANES-1];
    t_flags                         r_flg [0:CORDIC_STEPS][0:MHA_LANES-1];

    logic   [MHA_ANGLE_W-1:0] r_q     [0:MHA_LANES-1];
    t_flags                   r_flg_q [0:MHA_LANES-1];
    logic   [MHA_OUT_W-1:0]   r_heading [0:MHA_LANES-1];

    logic signed [MHA_IN_W-1:0] up     [0:MHA_LANES-1];
    logic signed [MHA_IN_W-1:0] across [0:MHA_LANES-1];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign up[0]     = i_x_reading;
    assign across[0] = i_y_reading;
    assign up[1]     = i_y_reading;
    assign across[1] = i_z_reading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CORDIC_STEPS+1:0], accept};
        end
    end

    for (genvar l = 0; l < MHA_LANES; l++) begin : g_lane
        logic [MHA_MAG_W-1:0] ax;
        logic [MHA_MAG_W-1:0] ay;
        logic [MHA_MAG_W-1:0] big;
        logic [MHA_MAG_W-1:0] little;
        logic                 swp;
        logic [MHA_ANGLE_W-1:0] res;
        logic [MHA_ANGLE_W-1:0] turn;

        always_comb begin
            ax     = across[l][MHA_IN_W-1] ? (MHA_MAG_W'(0) - {1'b1, across[l]})
                                           : {1'b0, across[l]};
            ay     = up[l][MHA_IN_W-1] ? (MHA_MAG_W'(0) - {1'b1, up[l]})
                                       : {1'b0, up[l]};
            swp    = ay > ax;
            big    = swp ? ay : ax;
            little = swp ? ax : ay;
        end

        always_ff @(posedge i_clk) begin
            r_cx[0][l] <= $signed({{(MHA_CORDIC_W-MHA_MAG_W-MHA_PRESCALE){1'b0}},
                                   big, {MHA_PRESCALE{1'b0}}});
            r_cy[0][l] <= $signed({{(MHA_CORDIC_W-MHA_MAG_W-MHA_PRESCALE){1'b0}},
                                   little, {MHA_PRESCALE{1'b0}}});
            r_z[0][l]  <= '0;
            r_flg[0][l].zero_small <= (little == '0);
            r_flg[0][l].equal      <= (little == big);
            r_flg[0][l].swapped    <= swp;
            r_flg[0][l].across_neg <= across[l][MHA_IN_W-1];
            r_flg[0][l].up_neg     <= up[l][MHA_IN_W-1];
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (!r_cy[i][l][MHA_CORDIC_W-1]) begin
                    r_cx[i+1][l] <= r_cx[i][l] + (r_cy[i][l] >>> i);
                    r_cy[i+1][l] <= r_cy[i][l] - (r_cx[i][l] >>> i);
                    r_z[i+1][l]  <= r_z[i][l] + MHA_ATAN_TURNS[i];
                end else begin
                    r_cx[i+1][l] <= r_cx[i][l] - (r_cy[i][l] >>> i);
                    r_cy[i+1][l] <= r_cy[i][l] + (r_cx[i][l] >>> i);
                    r_z[i+1][l]  <= r_z[i][l] - MHA_ATAN_TURNS[i];
                end
                r_flg[i+1][l] <= r_flg[i][l];
            end
        end

        always_comb begin
            if (r_flg[CORDIC_STEPS][l].zero_small) begin
                res = '0;
            end else if (r_flg[CORDIC_STEPS][l].equal) begin
                res = MHA_EIGHTH_TURN;
            end else begin
                res = r_z[CORDIC_STEPS][l];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[l]     <= r_flg[CORDIC_STEPS][l].swapped ? (MHA_QUARTER_TURN - res) : res;
            r_flg_q[l] <= r_flg[CORDIC_STEPS][l];
        end

        always_comb begin
            case ({r_flg_q[l].across_neg, r_flg_q[l].up_neg})
                2'b00:   turn = r_q[l];
                2'b01:   turn = MHA_ANGLE_W'(0) - r_q[l];
                2'b10:   turn = MHA_HALF_TURN - r_q[l];
                2'b11:   turn = MHA_HALF_TURN + r_q[l];
                default: turn = r_q[l];
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_heading[l] <= turn[MHA_ANGLE_W-1 -: MHA_OUT_W];
        end
    end

    assign o_done       = r_vld[CORDIC_STEPS+2];
    assign o_heading_xy = r_heading[0];
    assign o_heading_yz = r_heading[1];

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy rose although the pipeline never stalls");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("accepted transaction did not complete after the pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted transaction");

    a_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_x_reading == '0 && i_y_reading == '0, LAT)) |-> (o_heading_xy == '0))
        else $error("zero X and Y did not give a zero heading");

endmodule

`default_nettype wire
